[rtl/dda_line_rasterizer_assert.svh]
// assertion macros shared by the rasteriser checker
// no dependencies; pulled in by the checker file
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlr check failed");

// next-cycle implication, disabled while reset is asserted
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlr check failed");

`endif

[rtl/dlr_pkg.sv]
// shared types for the dda line rasteriser: controller states, command and status
// no dependencies
package dlr_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic div_step;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic short_seg;
        logic div_last;
        logic out_free;
        logic final_pix;
    } t_status;

endpackage

[rtl/dlr_if.sv]
// valid/ready stream interfaces for segments in and pixels out
// no dependencies
interface dlr_seg_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pix_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;
    logic                  clipped;

    modport source (output valid, pixel_x, pixel_y, last, clipped, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, clipped, output ready);
endinterface

[rtl/dlr_div.sv]
// restoring divider, one quotient bit per cycle while i_step is high: floor(mag * 2^FRAC_BITS / span)
// no package dependency; used twice by dlr_dpath
module dlr_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_step,
    input  logic [COORD_BITS-1:0] i_mag,
    input  logic [COORD_BITS-1:0] i_span,
    output logic [FRAC_BITS:0]    o_quot
);
    // remainder stays below twice the span
    logic [COORD_BITS:0] r_rem;
    logic [COORD_BITS:0] n_rem;
    logic [COORD_BITS:0] diff;
    logic [FRAC_BITS:0]  r_quot;
    logic                ge;

    always_comb begin
        ge   = (r_rem >= {1'b0, i_span});
        diff = r_rem - {1'b0, i_span};
        if (ge) begin
            n_rem = {diff[COORD_BITS-1:0], 1'b0};
        end else begin
            n_rem = {r_rem[COORD_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= {1'b0, i_mag};
            r_quot <= '0;
        end else if (i_step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[FRAC_BITS-1:0], ge};
        end
    end

    assign o_quot = r_quot;
endmodule

[rtl/dlr_ctrl.sv]
// controller state machine for the rasteriser
// depends on dlr_pkg
module dlr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seg_valid,
    output logic             o_seg_ready,
    input  dlr_pkg::t_status i_status,
    output dlr_pkg::t_cmd    o_cmd
);
    import dlr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_seg_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = i_status.short_seg ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) n_state = S_RUN;
            end
            S_RUN: begin
                if (i_status.out_free && i_status.final_pix) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_seg_ready    = (r_state == S_IDLE);
        o_cmd.load     = (r_state == S_IDLE) && i_seg_valid;
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.step     = (r_state == S_RUN) && i_status.out_free;
    end
endmodule

[rtl/dlr_dpath.sv]
// datapath: deltas, span, two increment dividers, accumulators, output register
// depends on dlr_pkg and dlr_div
module dlr_dpath #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16,
    parameter int MAX_SPAN   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dlr_pkg::t_cmd         i_cmd,
    output dlr_pkg::t_status      o_status,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic                  i_pix_ready,
    output logic                  o_pix_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last,
    output logic                  o_clipped
);
    import dlr_pkg::*;

    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(MAX_SPAN);
    localparam int BIT_W = $clog2(FRAC_BITS + 1);

    logic [COORD_BITS-1:0] r_xs, r_ys, r_adx, r_ady, r_span;
    logic                  r_xneg, r_yneg, r_clip;
    logic [BIT_W-1:0]      r_bit;
    logic [CNT_W-1:0]      r_steps;
    logic [ACC_W-1:0]      r_xacc, r_yacc, n_xacc, n_yacc;
    logic [FRAC_BITS:0]    x_quot, y_quot;
    logic [COORD_BITS-1:0] span_c;
    logic                  clip_c;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_last, r_clip_out;

    always_comb begin
        span_c = (r_adx > r_ady) ? r_adx : r_ady;
        clip_c = (32'(span_c) > MAX_SPAN);
        // increment sign applied as add or subtract of the magnitude
        n_xacc = r_xneg ? r_xacc - ACC_W'(x_quot) : r_xacc + ACC_W'(x_quot);
        n_yacc = r_yneg ? r_yacc - ACC_W'(y_quot) : r_yacc + ACC_W'(y_quot);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs   <= i_x_start;
            r_ys   <= i_y_start;
            r_xneg <= (i_x_end < i_x_start);
            r_yneg <= (i_y_end < i_y_start);
            r_adx  <= (i_x_end >= i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
            r_ady  <= (i_y_end >= i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
        end
        if (i_cmd.setup) begin
            r_span <= span_c;
            r_clip <= clip_c;
            r_xacc <= {r_xs, {FRAC_BITS{1'b0}}};
            r_yacc <= {r_ys, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.step) begin
            r_xacc     <= n_xacc;
            r_yacc     <= n_yacc;
            r_px       <= n_xacc[ACC_W-1:FRAC_BITS];
            r_py       <= n_yacc[ACC_W-1:FRAC_BITS];
            r_last     <= (r_steps == CNT_W'(1));
            r_clip_out <= r_clip;
        end
    end

    // control counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit       <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_bit   <= BIT_W'(FRAC_BITS);
                r_steps <= clip_c ? CNT_W'(MAX_SPAN - 1) : CNT_W'(span_c - COORD_BITS'(1));
            end else begin
                if (i_cmd.div_step) r_bit <= r_bit - BIT_W'(1);
                if (i_cmd.step) r_steps <= r_steps - CNT_W'(1);
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_pix_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk  (i_clk),
        .i_load (i_cmd.setup),
        .i_step (i_cmd.div_step),
        .i_mag  (r_adx),
        .i_span (r_span),
        .o_quot (x_quot)
    );

    dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk  (i_clk),
        .i_load (i_cmd.setup),
        .i_step (i_cmd.div_step),
        .i_mag  (r_ady),
        .i_span (r_span),
        .o_quot (y_quot)
    );

    always_comb begin
        o_status.short_seg = (span_c < COORD_BITS'(2));
        o_status.div_last  = (r_bit == '0);
        o_status.out_free  = !r_out_valid || i_pix_ready;
        o_status.final_pix = (r_steps == CNT_W'(1));
    end

    assign o_pix_valid = r_out_valid;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_last      = r_last;
    assign o_clipped   = r_clip_out;
endmodule

[rtl/dda_line_rasterizer.sv]
// top level of the dda line rasteriser: controller plus datapath
// depends on dlr_pkg, dlr_if, dlr_ctrl, dlr_dpath
//
//  port    | dir | transfer moves                        | flow
//  i_seg   | in  | x_start, y_start, x_end, y_end        | one segment per transfer
//  o_pix   | out | pixel_x, pixel_y, last, clipped       | 0 to MAX_SPAN-1 pixels per segment
//
// the increment division runs first, one quotient bit a cycle
// each pixel after that costs one accumulator add; pixels wait while o_pix is stalled
// spans of 0 or 1 go from setup straight back to idle with no pixel
// next segment is taken while the last pixel still sits in the output register
// synchronous active-low reset clears the state machine, counters and output valid
module dda_line_rasterizer #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16,
    parameter int MAX_SPAN   = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dlr_seg_if.sink   i_seg,
    dlr_pix_if.source o_pix
);
    import dlr_pkg::*;

    // command and status between the two halves
    t_cmd    cmd;
    t_status status;

    dlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg.valid),
        .o_seg_ready (i_seg.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath holds the output register, so pixel handshake lives there
    dlr_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .MAX_SPAN   (MAX_SPAN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_x_start   (i_seg.x_start),
        .i_y_start   (i_seg.y_start),
        .i_x_end     (i_seg.x_end),
        .i_y_end     (i_seg.y_end),
        .i_pix_ready (o_pix.ready),
        .o_pix_valid (o_pix.valid),
        .o_pixel_x   (o_pix.pixel_x),
        .o_pixel_y   (o_pix.pixel_y),
        .o_last      (o_pix.last),
        .o_clipped   (o_pix.clipped)
    );
endmodule

[rtl/dlr_chk.sv]
// port-level checker for the rasteriser, bound to the top level
// depends on dda_line_rasterizer_assert.svh
`include "dda_line_rasterizer_assert.svh"

module dlr_chk #(
    parameter int COORD_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_seg_valid,
    input logic                  i_seg_ready,
    input logic                  i_pix_valid,
    input logic                  i_pix_ready,
    input logic [COORD_BITS-1:0] i_pixel_x,
    input logic [COORD_BITS-1:0] i_pixel_y,
    input logic                  i_last,
    input logic                  i_clipped
);
    logic                    pix_stall;
    logic [2*COORD_BITS+1:0] pix_word;

    assign pix_stall = i_pix_valid && !i_pix_ready;
    assign pix_word  = {i_pixel_x, i_pixel_y, i_last, i_clipped};

    // stalled pixel holds
    `DLR_ASSERT_NEXT(a_pix_hold, i_clk, i_rst_n, pix_stall, i_pix_valid && $stable(pix_word))
    // one segment at a time: busy straight after a transfer in
    `DLR_ASSERT_NEXT(a_busy_after_seg, i_clk, i_rst_n, i_seg_valid && i_seg_ready, !i_seg_ready)
    // no new segment while a segment still has pixels to come
    `DLR_ASSERT_NOW(a_no_seg_mid_line, i_clk, i_rst_n, i_pix_valid && !i_last, !i_seg_ready)
endmodule

bind dda_line_rasterizer dlr_chk #(.COORD_BITS(COORD_BITS)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seg_valid (i_seg.valid),
    .i_seg_ready (i_seg.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pixel_x   (o_pix.pixel_x),
    .i_pixel_y   (o_pix.pixel_y),
    .i_last      (o_pix.last),
    .i_clipped   (o_pix.clipped)
);
